// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: rtl/core/pasm_pkg.sv
// ----------------------------------------------------------------------------
// pasm_pkg
// widths, fixed-point constants and beat types of the stability meter
// ----------------------------------------------------------------------------
package pasm_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int SPG_W          = 8;
    localparam int MEAS_W         = 12;
    localparam int MV_W           = 12;
    localparam int GROUPS_DEFAULT = 5;
    localparam int TDATA_IN_W     = 16;
    localparam int TDATA_OUT_W    = 24;
    localparam int TUSER_OUT_W    = 2;

    localparam logic [SPG_W-1:0] SPG_RESET = 8'd100;
    localparam logic [MV_W-1:0]  MV_MAX    = 12'd3299;

    // floor(x/10) for x below 16384
    localparam int           DIV10_SH    = 16;
    localparam logic [12:0]  DIV10_RECIP = 13'd6554;
    // floor(x/3) for x below 32768
    localparam int           DIV3_SH     = 16;
    localparam logic [14:0]  DIV3_RECIP  = 15'd21846;
    // x * 33000 / 4096
    localparam int           SCALE_SH    = 12;
    localparam logic [15:0]  MV_SCALE    = 16'd33000;
    // floor(x/10) for 16-bit x
    localparam int           DIV10W_SH    = 19;
    localparam logic [15:0]  DIV10W_RECIP = 16'd52429;

    localparam int SUM3_W   = 14;
    localparam int QUOT10_W = 10;
    localparam int SCALED_W = 16;

    typedef struct packed {
        logic              valid;
        logic [MEAS_W-1:0] meas;
    } t_meas_beat;

    typedef struct packed {
        logic [MEAS_W-1:0] meas;
        logic              checked;
        logic              stable;
        logic [MV_W-1:0]   mv;
    } t_result;

endpackage

// File: rtl/core/pasm_group_acc.sv
// ----------------------------------------------------------------------------
// pasm_group_acc
// per-sample group peak tracking, peak sum over groups and mean of the peaks
// ----------------------------------------------------------------------------
module pasm_group_acc #(
    parameter int GROUPS = pasm_pkg::GROUPS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [pasm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [pasm_pkg::SPG_W-1:0]    i_spg,
    output pasm_pkg::t_meas_beat          o_beat
);
    import pasm_pkg::*;

    localparam int GIDX_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int SUM_W   = SAMPLE_W + GIDX_W;
    localparam int DIV_SH  = SUM_W + 4;
    localparam int RECIP_W = DIV_SH + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(((1 << DIV_SH) + GROUPS - 1) / GROUPS);
    localparam logic [GIDX_W-1:0]  GIDX_LAST = GIDX_W'(GROUPS - 1);

    logic [SAMPLE_W-1:0] r_peak;
    logic [SPG_W-1:0]    r_sidx;
    logic [GIDX_W-1:0]   r_gidx;
    logic [SUM_W-1:0]    r_sum;
    logic                r_a_valid;
    logic [SUM_W-1:0]    r_a_sum;
    logic                r_b_valid;
    logic [MEAS_W-1:0]   r_b_meas;

    logic [SAMPLE_W-1:0] n_peak;
    logic                group_end;
    logic                meas_end;
    logic [SUM_W-1:0]    sum_now;
    logic [PROD_W-1:0]   prod;

    assign n_peak    = (r_sidx == '0 || i_sample > r_peak) ? i_sample : r_peak;
    assign group_end = ((SPG_W+1)'(r_sidx) + (SPG_W+1)'(1)) >= (SPG_W+1)'(i_spg);
    assign meas_end  = group_end && (r_gidx == GIDX_LAST);
    assign sum_now   = r_sum + SUM_W'(n_peak);
    assign prod      = PROD_W'(r_a_sum) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak    <= '0;
            r_sidx    <= '0;
            r_gidx    <= '0;
            r_sum     <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid && meas_end;
            r_b_valid <= r_a_valid;
            if (i_valid) begin
                if (!group_end) begin
                    r_peak <= n_peak;
                    r_sidx <= r_sidx + SPG_W'(1);
                end else begin
                    r_peak <= '0;
                    r_sidx <= '0;
                    if (meas_end) begin
                        r_gidx <= '0;
                        r_sum  <= '0;
                    end else begin
                        r_gidx <= r_gidx + GIDX_W'(1);
                        r_sum  <= sum_now;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_sum  <= sum_now;
            r_b_meas <= prod[DIV_SH +: MEAS_W];
        end
    end

    assign o_beat.valid = r_b_valid;
    assign o_beat.meas  = r_b_meas;

endmodule

// File: rtl/core/pasm_window.sv
// ----------------------------------------------------------------------------
// pasm_window
// triple collection, ten percent stability check and millivolt scaling
// ----------------------------------------------------------------------------
module pasm_window (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  pasm_pkg::t_meas_beat i_beat,
    output logic                 o_valid,
    output pasm_pkg::t_result    o_result
);
    import pasm_pkg::*;

    localparam logic [1:0] FILL_LAST = 2'd2;

    logic [MEAS_W-1:0]   r_m0;
    logic [MEAS_W-1:0]   r_m1;
    logic [1:0]          r_fill;
    logic                r_c_valid;
    logic [MEAS_W-1:0]   r_c_meas;
    logic                r_c_checked;
    logic                r_c_stable;
    logic [MEAS_W-1:0]   r_c_mean;
    logic                r_d_valid;
    logic [MEAS_W-1:0]   r_d_meas;
    logic                r_d_checked;
    logic                r_d_stable;
    logic [SCALED_W-1:0] r_d_scaled;
    logic [MV_W-1:0]     r_acc_mv;

    logic [MEAS_W-1:0]   m3;
    logic [MEAS_W:0]     m3_p9;
    logic [25:0]         prod_up;
    logic [25:0]         prod_dn;
    logic [QUOT10_W-1:0] q_up;
    logic [QUOT10_W-1:0] q_dn;
    logic [MEAS_W:0]     lim_up;
    logic [MEAS_W-1:0]   lim_dn;
    logic                tol0;
    logic                tol1;
    logic                last;
    logic [SUM3_W-1:0]   sum3;
    logic [28:0]         prod3;
    logic [27:0]         prod_sc;
    logic [30:0]         prod_mv;
    logic [MV_W-1:0]     mv_new;

    assign m3      = i_beat.meas;
    assign m3_p9   = (MEAS_W+1)'(m3) + (MEAS_W+1)'(9);
    assign prod_up = 26'(m3) * 26'(DIV10_RECIP);
    assign prod_dn = 26'(m3_p9) * 26'(DIV10_RECIP);
    assign q_up    = prod_up[DIV10_SH +: QUOT10_W];
    assign q_dn    = prod_dn[DIV10_SH +: QUOT10_W];
    assign lim_up  = (MEAS_W+1)'(m3) + (MEAS_W+1)'(q_up);
    assign lim_dn  = m3 - MEAS_W'(q_dn);
    assign tol0    = (r_m0 >= lim_dn) && ((MEAS_W+1)'(r_m0) <= lim_up);
    assign tol1    = (r_m1 >= lim_dn) && ((MEAS_W+1)'(r_m1) <= lim_up);
    assign last    = (r_fill == FILL_LAST);
    assign sum3    = SUM3_W'(r_m0) + SUM3_W'(r_m1) + SUM3_W'(m3);
    assign prod3   = 29'(sum3) * 29'(DIV3_RECIP);
    assign prod_sc = 28'(r_c_mean) * 28'(MV_SCALE);
    assign prod_mv = 31'(r_d_scaled) * 31'(DIV10W_RECIP);
    assign mv_new  = prod_mv[DIV10W_SH +: MV_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m0      <= '0;
            r_m1      <= '0;
            r_fill    <= '0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_acc_mv  <= '0;
        end else if (i_en) begin
            r_c_valid <= i_beat.valid;
            r_d_valid <= r_c_valid;
            if (i_beat.valid) begin
                if (last) begin
                    r_fill <= '0;
                end else begin
                    r_fill <= r_fill + 2'd1;
                    if (r_fill == 2'd0) begin
                        r_m0 <= m3;
                    end else begin
                        r_m1 <= m3;
                    end
                end
            end
            if (r_d_valid && r_d_stable) begin
                r_acc_mv <= mv_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_meas    <= m3;
            r_c_checked <= last;
            r_c_stable  <= last && tol0 && tol1;
            r_c_mean    <= prod3[DIV3_SH +: MEAS_W];
            r_d_meas    <= r_c_meas;
            r_d_checked <= r_c_checked;
            r_d_stable  <= r_c_stable;
            r_d_scaled  <= prod_sc[SCALE_SH +: SCALED_W];
        end
    end

    assign o_valid          = r_d_valid;
    assign o_result.meas    = r_d_meas;
    assign o_result.checked = r_d_checked;
    assign o_result.stable  = r_d_stable;
    assign o_result.mv      = r_d_stable ? mv_new : r_acc_mv;

endmodule

// File: rtl/core/peak_amplitude_stability_meter.sv
// ----------------------------------------------------------------------------
// peak_amplitude_stability_meter
// group peak averaging of adc samples with a three-measurement stability check
// ----------------------------------------------------------------------------
// s_axis carries one 12-bit sample per beat in tdata[11:0]. every
// samples_per_group samples close a group, every GROUPS groups close a
// measurement, and each measurement gives one m_axis beat: tdata holds the
// measurement and the accepted millivolt level, tuser the window-checked and
// stable flags. samples produce no beat otherwise.
// the cfg channel writes samples_per_group at any time the block is idle;
// o_cfg_ready is always high.
// one sample is taken every cycle while s_axis_tready is high. a result goes
// from the beat of the sample that closed its measurement to m_axis_tvalid
// through one register each for the group accumulate, the divide by GROUPS,
// the window check and the millivolt scaling, then the output register.
// the output has a register plus a one-beat skid; while the skid holds a beat
// s_axis_tready is low and the whole pipeline holds, so a stalled receiver
// loses nothing.
// reset clears all counters, the collected triple and the level to zero and
// sets samples_per_group to 100.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module peak_amplitude_stability_meter #(
    parameter int GROUPS = pasm_pkg::GROUPS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [pasm_pkg::TDATA_IN_W-1:0]  s_axis_tdata,   // sample
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [pasm_pkg::TDATA_OUT_W-1:0] m_axis_tdata,   // measurement, millivolts
    output logic [pasm_pkg::TUSER_OUT_W-1:0] m_axis_tuser,   // window_checked, stable
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pasm_pkg::SPG_W-1:0]       i_cfg_data
);
    import pasm_pkg::*;

    logic [SPG_W-1:0] r_spg;
    logic             r_out_valid;
    logic             r_skid_valid;
    t_result          r_out;
    t_result          r_skid;

    logic       en;
    logic       new_valid;
    logic       out_taken;
    logic       win_valid;
    t_meas_beat meas_beat;
    t_result    win_result;

    assign o_cfg_ready = 1'b1;
    assign en          = !r_skid_valid;
    assign new_valid   = win_valid && en;
    assign out_taken   = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spg <= SPG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_spg <= i_cfg_data;
        end
    end

    pasm_group_acc #(
        .GROUPS (GROUPS)
    ) u_group_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (s_axis_tvalid),
        .i_sample (s_axis_tdata[SAMPLE_W-1:0]),
        .i_spg    (r_spg),
        .o_beat   (meas_beat)
    );

    pasm_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_beat   (meas_beat),
        .o_valid  (win_valid),
        .o_result (win_result)
    );

    // output register with one-beat skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_taken) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= new_valid;
            end
        end else if (!r_out_valid) begin
            r_out_valid <= new_valid;
        end else if (new_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_taken) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (new_valid) begin
                r_out <= win_result;
            end
        end else if (!r_out_valid && new_valid) begin
            r_out <= win_result;
        end
        if (r_out_valid && !m_axis_tready && new_valid) begin
            r_skid <= win_result;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.mv, r_out.meas};
    assign m_axis_tuser  = {r_out.stable, r_out.checked};

    `ASSERT_IMPLIES(a_stable_needs_check, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0])
    `ASSERT_IMPLIES(a_mv_in_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[TDATA_OUT_W-1:MEAS_W] <= MV_MAX)
    `ASSERT_IMPLIES(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && m_axis_tready, r_out_valid && !r_skid_valid)

endmodule

// File: bench/peak_amplitude_stability_meter_test.sv
// ----------------------------------------------------------------------------
// peak_amplitude_stability_meter_test
// self-checking bench: a directed table of samples and group-length writes,
// then random phases of steady and noisy sample runs at several group lengths.
// every sample beat updates an in-bench model of the peak, mean and
// triple-stability logic; every measurement beat is compared field by field.
// ----------------------------------------------------------------------------
module peak_amplitude_stability_meter_test;
    import pasm_pkg::*;

    localparam int GROUPS        = GROUPS_DEFAULT;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int IDLE_PCT      = 17;
    localparam int SAMPLE_MAX    = 4095;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [11:0]       value;
        int                count;
        bit                typed;
        t_result           want;
    } t_script_row;

    typedef struct {
        t_result want;
        bit      typed;
        t_result fixed;
    } t_reading;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic [TUSER_OUT_W-1:0] m_axis_tuser;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [SPG_W-1:0]       i_cfg_data    = '0;

    // model state
    logic [SPG_W-1:0]    grp_len      = SPG_RESET;
    logic [SAMPLE_W-1:0] run_peak     = '0;
    logic [7:0]          run_count    = '0;
    logic [3:0]          group_count  = '0;
    logic [15:0]         peak_total   = '0;
    logic [MEAS_W-1:0]   triple_meas [3] = '{default: '0};
    logic [1:0]          triple_fill  = '0;
    logic [MV_W-1:0]     level_mv     = '0;

    t_reading pending_readings [$];

    int      typed_at     = -1;
    t_result typed_want   = '0;
    int      n_taken      = 0;
    int      samples_sent = 0;
    int      n_results    = 0;
    int      n_checked    = 0;
    int      n_stable     = 0;
    int      mismatches   = 0;
    int      stall_cycles = 0;
    bit      steady_flow  = 1'b0;
    bit      hold_req     = 1'b0;
    string   len_log      = "";

    // sample generator state
    int level      = 0;
    int spread     = 0;
    bit noisy      = 1'b0;
    int burst_left = 0;

    t_script_row script [16] = '{
        '{ROW_SAMPLE, 12'd4095, 99, 1'b0, '0},
        '{ROW_CFG,    12'd0,     1, 1'b0, '0},
        '{ROW_SAMPLE, 12'd4095,  4, 1'b0, '0},
        '{ROW_SAMPLE, 12'd4095,  1, 1'b1, '{12'd4095, 1'b0, 1'b0, 12'd0}},
        '{ROW_SAMPLE, 12'd4095,  4, 1'b0, '0},
        '{ROW_SAMPLE, 12'd4095,  1, 1'b1, '{12'd4095, 1'b0, 1'b0, 12'd0}},
        '{ROW_SAMPLE, 12'd4095,  4, 1'b0, '0},
        '{ROW_SAMPLE, 12'd4095,  1, 1'b1, '{12'd4095, 1'b1, 1'b1, 12'd3299}},
        '{ROW_SAMPLE, 12'd0,     4, 1'b0, '0},
        '{ROW_SAMPLE, 12'd0,     1, 1'b1, '{12'd0, 1'b0, 1'b0, 12'd3299}},
        '{ROW_CFG,    12'd4,     1, 1'b0, '0},
        '{ROW_SAMPLE, 12'd1,     1, 1'b0, '0},
        '{ROW_SAMPLE, 12'd2,     1, 1'b0, '0},
        '{ROW_SAMPLE, 12'd3,     1, 1'b0, '0},
        '{ROW_CFG,    12'd2,     1, 1'b0, '0},
        '{ROW_SAMPLE, 12'd7,     1, 1'b0, '0}
    };

    peak_amplitude_stability_meter #(
        .GROUPS(GROUPS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // measurement, millivolts
        .m_axis_tuser  (m_axis_tuser),   // window_checked, stable
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit near_anchor(input int m, input int anchor);
        int up;
        int down;
        up   = anchor + anchor / 10;
        down = anchor - (anchor + 9) / 10;
        return (m >= down) && (m <= up);
    endfunction

    task automatic take_sample(input logic [SAMPLE_W-1:0] s);
        t_reading r;
        int       serial;
        int       mean3;
        serial  = n_taken;
        n_taken = n_taken + 1;
        if (run_count == 0 || s > run_peak) begin
            run_peak = s;
        end
        if (int'(run_count) + 1 < int'(grp_len)) begin
            run_count = run_count + 1'b1;
            return;
        end
        run_count  = '0;
        peak_total = peak_total + 16'(run_peak);
        run_peak   = '0;
        if (int'(group_count) + 1 < GROUPS) begin
            group_count = group_count + 1'b1;
            return;
        end
        group_count  = '0;
        r.want.meas  = MEAS_W'(int'(peak_total) / GROUPS);
        peak_total   = '0;
        r.want.checked = 1'b0;
        r.want.stable  = 1'b0;
        triple_meas[triple_fill] = r.want.meas;
        if (triple_fill >= 2) begin
            triple_fill    = '0;
            r.want.checked = 1'b1;
            if (near_anchor(int'(triple_meas[0]), int'(triple_meas[2])) &&
                near_anchor(int'(triple_meas[1]), int'(triple_meas[2]))) begin
                mean3 = (int'(triple_meas[0]) + int'(triple_meas[1]) +
                         int'(triple_meas[2])) / 3;
                r.want.stable = 1'b1;
                level_mv      = MV_W'((mean3 * 33000 / 4096) / 10);
            end
        end else begin
            triple_fill = triple_fill + 1'b1;
        end
        r.want.mv = level_mv;
        r.typed   = (serial == typed_at);
        r.fixed   = typed_want;
        pending_readings.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                grp_len = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                take_sample(s_axis_tdata[SAMPLE_W-1:0]);
            end
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic compare_reading(input t_result got, input t_result want, input string src);
        if (got.meas !== want.meas) begin
            report_mismatch({src, " measurement"}, got.meas, want.meas);
        end
        if (got.checked !== want.checked) begin
            report_mismatch({src, " window_checked"}, got.checked, want.checked);
        end
        if (got.stable !== want.stable) begin
            report_mismatch({src, " stable"}, got.stable, want.stable);
        end
        if (got.mv !== want.mv) begin
            report_mismatch({src, " millivolts"}, got.mv, want.mv);
        end
    endtask

    always @(posedge i_clk) begin
        t_result  got;
        t_reading r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.meas    = m_axis_tdata[MEAS_W-1:0];
            got.mv      = m_axis_tdata[MEAS_W +: MV_W];
            got.checked = m_axis_tuser[0];
            got.stable  = m_axis_tuser[1];
            n_results++;
            n_checked += got.checked;
            n_stable  += got.stable;
            if (pending_readings.size() == 0) begin
                report_mismatch("unexpected beat, measurement", got.meas, -1);
            end else begin
                r = pending_readings.pop_front();
                compare_reading(got, r.want, "model");
                if (r.typed) begin
                    compare_reading(got, r.fixed, "table");
                end
            end
        end
    end

    // output side
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no beat for %0d cycles, %0d readings outstanding",
                     stall_cycles, pending_readings.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // steady runs near one level, with bursts of noise
    function automatic logic [SAMPLE_W-1:0] next_sample();
        int pick;
        int v;
        if (burst_left == 0) begin
            burst_left = (grp_len == 0 ? 1 : int'(grp_len)) * GROUPS *
                         ($urandom_range(0, 3) == 0 ? 1 : 3);
            pick  = $urandom_range(0, 99);
            noisy = (pick < 20);
            if (pick < 45) begin
                level = $urandom_range(0, 40);
            end else if (pick < 60) begin
                level = $urandom_range(3900, SAMPLE_MAX);
            end else begin
                level = $urandom_range(0, SAMPLE_MAX);
            end
            spread = $urandom_range(0, level / 8 + 1);
        end
        burst_left--;
        if (noisy) begin
            return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        end
        v = level + $urandom_range(0, spread);
        return SAMPLE_W'(v > SAMPLE_MAX ? SAMPLE_MAX : v);
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_IN_W'(s);
        samples_sent++;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [SPG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        len_log = {len_log, $sformatf(" %0d", v)};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic play_phase(input int len, input int n, input bit quiet, input bit hold);
        settle();
        write_cfg(SPG_W'(len));
        steady_flow = quiet;
        if (hold) begin
            hold_req = 1'b1;
        end
        repeat (n) send_sample(next_sample());
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG) begin
                settle();
                write_cfg(script[i].value[SPG_W-1:0]);
            end else begin
                for (int k = 0; k < script[i].count; k++) begin
                    if (script[i].typed && k == script[i].count - 1) begin
                        typed_at   = samples_sent;
                        typed_want = script[i].want;
                    end
                    send_sample(script[i].value);
                end
            end
        end

        play_phase(1, 200, 1'b1, 1'b0);
        play_phase(2, 200, 1'b0, 1'b1);
        play_phase(255, 255, 1'b0, 1'b0);
        play_phase(0, 150, 1'b0, 1'b0);
        play_phase(3, 75, 1'b0, 1'b0);
        play_phase($urandom_range(1, 8), 75, 1'b0, 1'b0);
        play_phase($urandom_range(1, 8), 75, 1'b0, 1'b0);
        settle();

        $display("covered %0d samples, %0d measurements, %0d triples checked, %0d stable",
                 n_taken, n_results, n_checked, n_stable);
        $display("group lengths written:%s, one long output stall", len_log);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
